// ===== design/ugcr_pkg.sv =====
// Shared types, codes and range classification for the UTF-8 glyph class run splitter.
package ugcr_pkg;

    localparam logic [1:0] KIND_BASE  = 2'd0;
    localparam logic [1:0] KIND_EMOJI = 2'd1;
    localparam logic [1:0] KIND_ASIAN = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [20:0] BAD_CODE = 21'h00003F;
    localparam logic [20:0] MAX_CODE = 21'h10FFFF;

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  glyph_kind;
        logic [2:0]  byte_length;
        logic        starts_run;
        logic        last_of_item;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_dec_out;

    function automatic logic in_rng(logic [20:0] cp, logic [20:0] lo, logic [20:0] hi);
        in_rng = (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic is_base(logic [20:0] cp);
        is_base = in_rng(cp, 21'd32, 21'd126) || in_rng(cp, 21'd160, 21'd383)
            || in_rng(cp, 21'h2010, 21'h2027) || (cp == 21'h25CB) || (cp == 21'h25AA);
    endfunction

    function automatic logic is_emoji(logic [20:0] cp);
        is_emoji = (cp == 21'h203C) || (cp == 21'h2049) || (cp == 21'h2122)
            || (cp == 21'h2139) || in_rng(cp, 21'h2194, 21'h21AA)
            || in_rng(cp, 21'h231A, 21'h231B) || (cp == 21'h2328) || (cp == 21'h23CF)
            || in_rng(cp, 21'h23E9, 21'h23FA) || (cp == 21'h24C2)
            || in_rng(cp, 21'h25FB, 21'h25FE) || in_rng(cp, 21'h2600, 21'h27BF)
            || in_rng(cp, 21'h2934, 21'h2935) || in_rng(cp, 21'h2B00, 21'h2BFF)
            || (cp == 21'h200D) || (cp == 21'hFE0F) || in_rng(cp, 21'h1F000, 21'h1FFFF);
    endfunction

    function automatic logic is_asian(logic [20:0] cp);
        is_asian = in_rng(cp, 21'h3000, 21'h4DBF) || in_rng(cp, 21'h4E00, 21'h9FFF)
            || in_rng(cp, 21'hA000, 21'hA4CF) || in_rng(cp, 21'hAC00, 21'hD7A3)
            || in_rng(cp, 21'hF900, 21'hFAFF) || in_rng(cp, 21'hFF00, 21'hFFEF)
            || in_rng(cp, 21'h20000, 21'h2A6DF) || in_rng(cp, 21'h2A700, 21'h2EBEF);
    endfunction

endpackage

// ===== design/ugcr_classify.sv =====
// Sorts one codepoint into its glyph kind by the range tables in priority order.
module ugcr_classify (
    input  logic [20:0] i_code_point,
    output logic [1:0]  o_glyph_kind
);

    always_comb begin
        if (ugcr_pkg::is_base(i_code_point)) begin
            o_glyph_kind = ugcr_pkg::KIND_BASE;
        end else if (ugcr_pkg::is_emoji(i_code_point)) begin
            o_glyph_kind = ugcr_pkg::KIND_EMOJI;
        end else if (ugcr_pkg::is_asian(i_code_point)) begin
            o_glyph_kind = ugcr_pkg::KIND_ASIAN;
        end else begin
            o_glyph_kind = ugcr_pkg::KIND_OTHER;
        end
    end

endmodule

// ===== design/ugcr_decode.sv =====
// UTF-8 decoder state, run tracking and result formation for one byte.
module ugcr_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_text,
    input  logic                i_take,
    output ugcr_pkg::t_dec_out  o_dec
);

    logic [20:0] r_pv, n_pv;
    logic [1:0]  r_exp, n_exp;
    logic [2:0]  r_taken, n_taken;
    logic [1:0]  r_prev, n_prev;
    logic        r_have, n_have;

    logic        lead2, lead3, lead4, f_lead, is_cont;
    logic [20:0] f_cp, f_pv, ext_pv;
    logic [1:0]  f_exp;
    logic [2:0]  taken_inc;
    logic        v0, v1;
    logic [20:0] cp0, cp1;
    logic [2:0]  len0, len1;
    logic [1:0]  k0, k1;

    ugcr_classify u_cls0 (.i_code_point(cp0), .o_glyph_kind(k0));
    ugcr_classify u_cls1 (.i_code_point(cp1), .o_glyph_kind(k1));

    always_comb begin
        lead2     = (i_text_byte[7:5] == 3'b110);
        lead3     = (i_text_byte[7:4] == 4'b1110);
        lead4     = (i_text_byte[7:3] == 5'b11110);
        f_lead    = lead2 || lead3 || lead4;
        is_cont   = (i_text_byte[7:6] == 2'b10);
        f_cp      = i_text_byte[7] ? ugcr_pkg::BAD_CODE : {13'd0, i_text_byte};
        f_pv      = lead2 ? {16'd0, i_text_byte[4:0]}
                  : (lead3 ? {17'd0, i_text_byte[3:0]} : {18'd0, i_text_byte[2:0]});
        f_exp     = lead2 ? 2'd1 : (lead3 ? 2'd2 : 2'd3);
        ext_pv    = {r_pv[14:0], i_text_byte[5:0]};
        taken_inc = 3'(r_taken + 3'd1);

        v0 = 1'b0;
        v1 = 1'b0;
        cp0 = ugcr_pkg::BAD_CODE;
        cp1 = ugcr_pkg::BAD_CODE;
        len0 = 3'd1;
        len1 = 3'd1;
        n_pv = r_pv;
        n_exp = r_exp;
        n_taken = r_taken;

        if (r_exp == 2'd0) begin
            v0  = !f_lead || i_end_of_text;
            cp0 = f_lead ? ugcr_pkg::BAD_CODE : f_cp;
            if (f_lead) begin
                n_pv = f_pv;
                n_exp = f_exp;
                n_taken = 3'd1;
            end
        end else if (is_cont) begin
            n_pv = ext_pv;
            n_taken = taken_inc;
            n_exp = 2'(r_exp - 2'd1);
            len0 = taken_inc;
            if (r_exp == 2'd1) begin
                v0  = 1'b1;
                cp0 = (ext_pv > ugcr_pkg::MAX_CODE) ? ugcr_pkg::BAD_CODE : ext_pv;
                n_pv = '0;
                n_taken = 3'd0;
            end else begin
                v0 = i_end_of_text;
            end
        end else begin
            v0   = 1'b1;
            len0 = r_taken;
            v1   = !f_lead || i_end_of_text;
            cp1  = f_lead ? ugcr_pkg::BAD_CODE : f_cp;
            if (f_lead) begin
                n_pv = f_pv;
                n_exp = f_exp;
                n_taken = 3'd1;
            end else begin
                n_pv = '0;
                n_exp = 2'd0;
                n_taken = 3'd0;
            end
        end

        n_prev = r_prev;
        n_have = r_have;
        if (v1) begin
            n_prev = k1;
            n_have = 1'b1;
        end else if (v0) begin
            n_prev = k0;
            n_have = 1'b1;
        end

        if (i_end_of_text) begin
            n_pv = '0;
            n_exp = 2'd0;
            n_taken = 3'd0;
            n_prev = ugcr_pkg::KIND_BASE;
            n_have = 1'b0;
        end

        o_dec.v0 = v0;
        o_dec.v1 = v1;
        o_dec.r0.code_point   = cp0;
        o_dec.r0.glyph_kind   = k0;
        o_dec.r0.byte_length  = len0;
        o_dec.r0.starts_run   = !r_have || (k0 != r_prev);
        o_dec.r0.last_of_item = !v1;
        o_dec.r1.code_point   = cp1;
        o_dec.r1.glyph_kind   = k1;
        o_dec.r1.byte_length  = len1;
        o_dec.r1.starts_run   = (k1 != k0);
        o_dec.r1.last_of_item = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_exp <= 2'd0;
            r_taken <= 3'd0;
            r_prev <= ugcr_pkg::KIND_BASE;
            r_have <= 1'b0;
        end else if (i_take) begin
            r_pv <= n_pv;
            r_exp <= n_exp;
            r_taken <= n_taken;
            r_prev <= n_prev;
            r_have <= n_have;
        end
    end

endmodule

// ===== design/ugcr_out_buf.sv =====
// Two-entry result buffer that takes up to two results and gives one per transaction.
module ugcr_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  logic               i_push1,
    input  ugcr_pkg::t_result  i_data0,
    input  ugcr_pkg::t_result  i_data1,
    input  logic               i_pop,
    output logic [1:0]         o_free,
    output logic               o_valid,
    output ugcr_pkg::t_result  o_data
);

    ugcr_pkg::t_result r_ent [2];
    ugcr_pkg::t_result n_ent [2];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] base;

    always_comb begin
        base = 2'(r_cnt - {1'b0, i_pop});
        o_free = 2'(2'd2 - base);
        n_ent[0] = i_pop ? r_ent[1] : r_ent[0];
        n_ent[1] = r_ent[1];
        if (i_push0) begin
            n_ent[base[0]] = i_data0;
        end
        if (i_push1) begin
            n_ent[1] = i_data1;
        end
        n_cnt = 2'(base + {1'b0, i_push0} + {1'b0, i_push1});
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[0];

    always_ff @(posedge i_clk) begin
        r_ent[0] <= n_ent[0];
        r_ent[1] <= n_ent[1];
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/utf8_glyph_class_run_splitter_top.sv =====
// Top level of the UTF-8 glyph class run splitter: input register, decoder and result buffer.
// Path: an accepted byte is held in the input register, decoded combinationally and registered in the result buffer.
// Throughput: one byte per cycle while the result buffer has room for its results; a byte that
// causes two results holds the input until the result buffer has room for both, limited by the single output port.
// Reset: synchronous active-low i_rst_n clears the decoder, run tracking and both buffers.
module utf8_glyph_class_run_splitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_glyph_kind,
    output logic [2:0]  o_byte_length,
    output logic        o_starts_run,
    output logic        o_last_of_item
);

    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_eot;

    ugcr_pkg::t_dec_out dec;
    ugcr_pkg::t_result  head;
    logic [1:0] free;
    logic [1:0] need;
    logic       take;
    logic       pop;

    assign need    = 2'({1'b0, dec.v0} + {1'b0, dec.v1});
    assign take    = r_in_vld && (free >= need);
    assign pop     = o_valid && i_ready;
    assign o_ready = !r_in_vld || take;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_text_byte;
            r_eot <= i_end_of_text;
        end
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    ugcr_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (r_byte),
        .i_end_of_text (r_eot),
        .i_take        (take),
        .o_dec         (dec)
    );

    ugcr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (take && dec.v0),
        .i_push1 (take && dec.v1),
        .i_data0 (dec.r0),
        .i_data1 (dec.r1),
        .i_pop   (pop),
        .o_free  (free),
        .o_valid (o_valid),
        .o_data  (head)
    );

    assign o_code_point   = head.code_point;
    assign o_glyph_kind   = head.glyph_kind;
    assign o_byte_length  = head.byte_length;
    assign o_starts_run   = head.starts_run;
    assign o_last_of_item = head.last_of_item;

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && dec.v1) |-> dec.v0)
        else $error("second result without a first result");

    a_pair_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && dec.v1) |-> (free == 2'd2))
        else $error("two results pushed without room for both");

    a_pair_kept_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !o_last_of_item) |=> o_valid)
        else $error("second result of a byte missing after the first transaction");

    a_input_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_vld)
        else $error("accepted byte not held in the input register");

endmodule

// ===== tb/sv/utf8_glyph_run_checker.sv =====
// Checker that predicts the decoded glyph stream from accepted bytes and compares every result.
module utf8_glyph_run_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [20:0] i_code_point,
    input  logic [1:0]  i_glyph_kind,
    input  logic [2:0]  i_byte_length,
    input  logic        i_starts_run,
    input  logic        i_last_of_item,
    output int          o_fail_count,
    output int          o_pending
);

    ugcr_pkg::t_result glyph_q [$];
    ugcr_pkg::t_result step_res [2];
    int                step_n;
    logic [20:0]       acc_value;
    logic [1:0]        cont_left;
    logic [2:0]        taken_n;
    logic [1:0]        prev_kind;
    logic              prev_seen;
    int                fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic logic span(input logic [20:0] v, input int unsigned lo,
                                  input int unsigned hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [1:0] glyph_kind_of(input logic [20:0] cp);
        logic base_hit;
        logic emoji_hit;
        logic asian_hit;
        base_hit = span(cp, 32, 126) || span(cp, 160, 383) || span(cp, 'h2010, 'h2027)
            || span(cp, 'h25CB, 'h25CB) || span(cp, 'h25AA, 'h25AA);
        emoji_hit = span(cp, 'h203C, 'h203C) || span(cp, 'h2049, 'h2049)
            || span(cp, 'h2122, 'h2122) || span(cp, 'h2139, 'h2139)
            || span(cp, 'h2194, 'h21AA) || span(cp, 'h231A, 'h231B)
            || span(cp, 'h2328, 'h2328) || span(cp, 'h23CF, 'h23CF)
            || span(cp, 'h23E9, 'h23FA) || span(cp, 'h24C2, 'h24C2)
            || span(cp, 'h25FB, 'h25FE) || span(cp, 'h2600, 'h27BF)
            || span(cp, 'h2934, 'h2935) || span(cp, 'h2B00, 'h2BFF)
            || span(cp, 'h200D, 'h200D) || span(cp, 'hFE0F, 'hFE0F)
            || span(cp, 'h1F000, 'h1FFFF);
        asian_hit = span(cp, 'h3000, 'h303F) || span(cp, 'h3040, 'h30FF)
            || span(cp, 'h3100, 'h312F) || span(cp, 'h3130, 'h318F)
            || span(cp, 'h3190, 'h31FF) || span(cp, 'h3200, 'h33FF)
            || span(cp, 'h3400, 'h4DBF) || span(cp, 'h4E00, 'h9FFF)
            || span(cp, 'hA000, 'hA4CF) || span(cp, 'hAC00, 'hD7A3)
            || span(cp, 'hF900, 'hFAFF) || span(cp, 'hFF00, 'hFFEF)
            || span(cp, 'h20000, 'h2A6DF) || span(cp, 'h2A700, 'h2EBEF);
        if (base_hit) return ugcr_pkg::KIND_BASE;
        if (emoji_hit) return ugcr_pkg::KIND_EMOJI;
        if (asian_hit) return ugcr_pkg::KIND_ASIAN;
        return ugcr_pkg::KIND_OTHER;
    endfunction

    task automatic clear_decode();
        acc_value = '0;
        cont_left = '0;
        taken_n   = '0;
    endtask

    task automatic note_glyph(input logic [20:0] cp, input logic [2:0] len);
        logic [1:0] k;
        k = glyph_kind_of(cp);
        step_res[step_n].code_point   = cp;
        step_res[step_n].glyph_kind   = k;
        step_res[step_n].byte_length  = len;
        step_res[step_n].starts_run   = !prev_seen || (k != prev_kind);
        step_res[step_n].last_of_item = 1'b0;
        prev_kind = k;
        prev_seen = 1'b1;
        step_n++;
    endtask

    task automatic lead_byte(input logic [7:0] b);
        if (!b[7]) begin
            note_glyph({13'd0, b}, 3'd1);
        end else if (b[7:5] == 3'b110) begin
            acc_value = {16'd0, b[4:0]};
            cont_left = 2'd1;
            taken_n   = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
            acc_value = {17'd0, b[3:0]};
            cont_left = 2'd2;
            taken_n   = 3'd1;
        end else if (b[7:3] == 5'b11110) begin
            acc_value = {18'd0, b[2:0]};
            cont_left = 2'd3;
            taken_n   = 3'd1;
        end else begin
            note_glyph(ugcr_pkg::BAD_CODE, 3'd1);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eot);
        logic [20:0] cp;
        logic [2:0]  len;
        int          i;
        step_n = 0;
        if (cont_left == 2'd0) begin
            lead_byte(b);
        end else if (b[7:6] == 2'b10) begin
            acc_value = {acc_value[14:0], b[5:0]};
            taken_n   = taken_n + 3'd1;
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp  = acc_value;
                len = taken_n;
                clear_decode();
                note_glyph((cp > ugcr_pkg::MAX_CODE) ? ugcr_pkg::BAD_CODE : cp, len);
            end
        end else begin
            len = taken_n;
            clear_decode();
            note_glyph(ugcr_pkg::BAD_CODE, len);
            lead_byte(b);
        end
        if (eot) begin
            if (cont_left != 2'd0 && step_n < 2) note_glyph(ugcr_pkg::BAD_CODE, taken_n);
            clear_decode();
            prev_kind = ugcr_pkg::KIND_BASE;
            prev_seen = 1'b0;
        end
        if (step_n > 0) step_res[step_n - 1].last_of_item = 1'b1;
        for (i = 0; i < step_n; i++) glyph_q.insert(glyph_q.size(), step_res[i]);
    endtask

    task automatic check_glyph();
        ugcr_pkg::t_result want;
        if (glyph_q.size() == 0) begin
            fail_cnt++;
            $display("%0t: unexpected result cp=%h kind=%0d len=%0d run=%0b last=%0b",
                     $time, i_code_point, i_glyph_kind, i_byte_length, i_starts_run,
                     i_last_of_item);
        end else begin
            want = glyph_q.pop_front();
            if (want.code_point !== i_code_point || want.glyph_kind !== i_glyph_kind
                || want.byte_length !== i_byte_length || want.starts_run !== i_starts_run
                || want.last_of_item !== i_last_of_item) begin
                fail_cnt++;
                $display("%0t: mismatch expected cp=%h kind=%0d len=%0d run=%0b last=%0b",
                         $time, want.code_point, want.glyph_kind, want.byte_length,
                         want.starts_run, want.last_of_item);
                $display("%0t:          actual cp=%h kind=%0d len=%0d run=%0b last=%0b",
                         $time, i_code_point, i_glyph_kind, i_byte_length, i_starts_run,
                         i_last_of_item);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decode();
            prev_kind = ugcr_pkg::KIND_BASE;
            prev_seen = 1'b0;
            glyph_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_glyph();
            if (i_in_valid && i_in_ready) predict_byte(i_text_byte, i_end_of_text);
        end
        o_pending <= glyph_q.size();
    end

endmodule

// ===== tb/sv/utf8_glyph_class_run_splitter_top_tb.sv =====
// Testbench top that feeds directed and random UTF-8 byte streams to the splitter and reports.
module utf8_glyph_class_run_splitter_top_tb;

    localparam int ITEMS     = 2000;
    localparam int LIMIT     = 400000;
    localparam int QUIET_RUN = 150;
    localparam int DRAIN     = 16;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_text_byte   = 8'd0;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [20:0] o_code_point;
    logic [1:0]  o_glyph_kind;
    logic [2:0]  o_byte_length;
    logic        o_starts_run;
    logic        o_last_of_item;

    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    int   sent_n    = 0;
    int   gap_pct   = 10;
    logic quiet     = 1'b0;
    logic held      = 1'b0;

    always #1 i_clk = ~i_clk;

    utf8_glyph_class_run_splitter_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_point   (o_code_point),
        .o_glyph_kind   (o_glyph_kind),
        .o_byte_length  (o_byte_length),
        .o_starts_run   (o_starts_run),
        .o_last_of_item (o_last_of_item)
    );

    utf8_glyph_run_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_code_point   (o_code_point),
        .i_glyph_kind   (o_glyph_kind),
        .i_byte_length  (o_byte_length),
        .i_starts_run   (o_starts_run),
        .i_last_of_item (o_last_of_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic int unsigned span_edge(input int idx);
        case (idx)
            0: return 32;         1: return 126;        2: return 160;
            3: return 383;        4: return 'h2010;     5: return 'h2027;
            6: return 'h25CB;     7: return 'h25AA;     8: return 'h203C;
            9: return 'h2049;     10: return 'h2122;    11: return 'h2139;
            12: return 'h2194;    13: return 'h21AA;    14: return 'h231A;
            15: return 'h231B;    16: return 'h2328;    17: return 'h23CF;
            18: return 'h23E9;    19: return 'h23FA;    20: return 'h24C2;
            21: return 'h25FB;    22: return 'h25FE;    23: return 'h2600;
            24: return 'h27BF;    25: return 'h2934;    26: return 'h2935;
            27: return 'h2B00;    28: return 'h2BFF;    29: return 'h200D;
            30: return 'hFE0F;    31: return 'h1F000;   32: return 'h1FFFF;
            33: return 'h3000;    34: return 'h4DBF;    35: return 'h4E00;
            36: return 'h9FFF;    37: return 'hA000;    38: return 'hA4CF;
            39: return 'hAC00;    40: return 'hD7A3;    41: return 'hF900;
            42: return 'hFAFF;    43: return 'hFF00;    44: return 'hFFEF;
            45: return 'h20000;   46: return 'h2A6DF;   47: return 'h2A700;
            48: return 'h2EBEF;   49: return 'h7F;      50: return 'h7FF;
            51: return 'h800;     52: return 'hFFFF;    53: return 'h10000;
            default: return 'h10FFFF;
        endcase
    endfunction

    function automatic logic [20:0] pick_code();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 'h7F);
            1: v = $urandom_range('h80, 'h7FF);
            2: v = $urandom_range('h800, 'hFFFF);
            3: v = $urandom_range('h10000, 'h10FFFF);
            default: begin
                v = span_edge($urandom_range(0, 54)) + $urandom_range(0, 2);
                v = (v == 0) ? 0 : v - 1;
                if (v > 'h10FFFF) v = 'h10FFFF;
            end
        endcase
        return v[20:0];
    endfunction

    function automatic int natural_len(input logic [20:0] cp);
        if (cp < 'h80) return 1;
        if (cp < 'h800) return 2;
        if (cp < 'h10000) return 3;
        return 4;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic eot);
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_n++;
        if (sent_n >= ITEMS - QUIET_RUN) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Sends the first keep bytes of an n-byte encoding, with end of text on the last one sent.
    task automatic put_code(input logic [20:0] cp, input int n, input int keep, input logic eot);
        logic [7:0] seq [4];
        int         i;
        case (n)
            1: seq[0] = cp[7:0];
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < keep; i++) put_byte(seq[i], eot && (i == keep - 1));
    endtask

    initial begin : watchdog
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : receiver
        @(posedge i_clk);
        forever begin
            if (!held && cycle_cnt > 1500) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [20:0] cp;
        int          n;
        int          pick;
        int          mix_mark;
        mix_mark = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b1);
        put_code(21'h0000A0, 2, 2, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hF8, 1'b0);
        put_code(21'h002010, 3, 3, 1'b0);
        put_code(21'h01F600, 4, 4, 1'b0);
        put_code(21'h110000, 4, 4, 1'b0);
        // A sequence broken by an ASCII byte, then one broken by a new lead byte.
        put_byte(8'hE4, 1'b0);
        put_byte(8'h41, 1'b0);
        put_byte(8'hC3, 1'b0);
        put_code(21'h004E00, 3, 3, 1'b0);
        // End of text in the middle of a sequence, then on a lead byte that breaks one.
        put_code(21'h004E00, 3, 2, 1'b1);
        put_byte(8'hC3, 1'b0);
        put_byte(8'hE4, 1'b1);

        while (sent_n < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                cp = pick_code();
                n  = natural_len(cp);
                if (n < 4 && $urandom_range(0, 7) == 0) n = $urandom_range(n + 1, 4);
                put_code(cp, n, n, $urandom_range(0, 19) == 0);
            end else if (pick < 85) begin
                cp = 21'($urandom_range('h110000, 'h1FFFFF));
                put_code(cp, 4, 4, $urandom_range(0, 19) == 0);
            end else if (pick < 95) begin
                cp = pick_code();
                n  = natural_len(cp);
                if (n == 1) n = $urandom_range(2, 4);
                put_code(cp, n, $urandom_range(1, n - 1), $urandom_range(0, 2) == 0);
            end else begin
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            if (sent_n - mix_mark >= 64) begin
                mix_mark = sent_n;
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ugcr_pkg.sv
design/ugcr_classify.sv
design/ugcr_decode.sv
design/ugcr_out_buf.sv
design/utf8_glyph_class_run_splitter_top.sv
tb/sv/utf8_glyph_run_checker.sv
tb/sv/utf8_glyph_class_run_splitter_top_tb.sv
